>>> sv/jtm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jtm_pkg;

    typedef logic [3:0] tap_state_t;

    localparam tap_state_t TAP_RESET      = 4'd0;
    localparam tap_state_t TAP_IDLE       = 4'd1;
    localparam tap_state_t TAP_SELECT_DR  = 4'd2;
    localparam tap_state_t TAP_CAPTURE_DR = 4'd3;
    localparam tap_state_t TAP_SHIFT_DR   = 4'd4;
    localparam tap_state_t TAP_EXIT1_DR   = 4'd5;
    localparam tap_state_t TAP_PAUSE_DR   = 4'd6;
    localparam tap_state_t TAP_EXIT2_DR   = 4'd7;
    localparam tap_state_t TAP_UPDATE_DR  = 4'd8;
    localparam tap_state_t TAP_SELECT_IR  = 4'd9;
    localparam tap_state_t TAP_CAPTURE_IR = 4'd10;
    localparam tap_state_t TAP_SHIFT_IR   = 4'd11;
    localparam tap_state_t TAP_EXIT1_IR   = 4'd12;
    localparam tap_state_t TAP_PAUSE_IR   = 4'd13;
    localparam tap_state_t TAP_EXIT2_IR   = 4'd14;
    localparam tap_state_t TAP_UPDATE_IR  = 4'd15;

    typedef enum logic [1:0] {
        KIND_RESET = 2'd0,
        KIND_MOVE  = 2'd1,
        KIND_SHIFT = 2'd2,
        KIND_NONE  = 2'd3
    } cmd_kind_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_RESET,
        SEQ_MOVE,
        SEQ_SHIFT
    } seq_state_t;

    localparam logic [3:0] MIN_RESET_CLOCKS = 4'd5;
    localparam logic [3:0] RESET_CLOCKS_DEFAULT = 4'd5;

    typedef struct packed {
        logic advance;
        logic tms;
    } tap_step_t;

    typedef struct packed {
        logic load;
        logic shift;
    } shift_ctl_t;

    function automatic tap_state_t tap_next(input tap_state_t cur, input logic tms);
        tap_state_t nxt;
        nxt = TAP_RESET;
        unique case (cur)
            TAP_RESET:      nxt = tms ? TAP_RESET     : TAP_IDLE;
            TAP_IDLE:       nxt = tms ? TAP_SELECT_DR : TAP_IDLE;
            TAP_SELECT_DR:  nxt = tms ? TAP_SELECT_IR : TAP_CAPTURE_DR;
            TAP_CAPTURE_DR: nxt = tms ? TAP_EXIT1_DR  : TAP_SHIFT_DR;
            TAP_SHIFT_DR:   nxt = tms ? TAP_EXIT1_DR  : TAP_SHIFT_DR;
            TAP_EXIT1_DR:   nxt = tms ? TAP_UPDATE_DR : TAP_PAUSE_DR;
            TAP_PAUSE_DR:   nxt = tms ? TAP_EXIT2_DR  : TAP_PAUSE_DR;
            TAP_EXIT2_DR:   nxt = tms ? TAP_UPDATE_DR : TAP_SHIFT_DR;
            TAP_UPDATE_DR:  nxt = tms ? TAP_SELECT_DR : TAP_IDLE;
            TAP_SELECT_IR:  nxt = tms ? TAP_RESET     : TAP_CAPTURE_IR;
            TAP_CAPTURE_IR: nxt = tms ? TAP_EXIT1_IR  : TAP_SHIFT_IR;
            TAP_SHIFT_IR:   nxt = tms ? TAP_EXIT1_IR  : TAP_SHIFT_IR;
            TAP_EXIT1_IR:   nxt = tms ? TAP_UPDATE_IR : TAP_PAUSE_IR;
            TAP_PAUSE_IR:   nxt = tms ? TAP_EXIT2_IR  : TAP_PAUSE_IR;
            TAP_EXIT2_IR:   nxt = tms ? TAP_UPDATE_IR : TAP_SHIFT_IR;
            TAP_UPDATE_IR:  nxt = tms ? TAP_SELECT_DR : TAP_IDLE;
            default:        nxt = TAP_RESET;
        endcase
        return nxt;
    endfunction

    // Bit (target * 16 + state) is the TMS level of the first step on a
    // shortest path from state to target; TMS low wins a tie.
    function automatic logic [255:0] build_hop_table();
        int hops [16];
        logic [255:0] tab;
        int tg;
        int p;
        int s;
        int d0;
        int d1;
        tab = '0;
        for (tg = 0; tg < 16; tg++) begin
            for (s = 0; s < 16; s++) begin
                hops[s] = 255;
            end
            hops[tg] = 0;
            for (p = 0; p < 16; p++) begin
                for (s = 0; s < 16; s++) begin
                    d0 = hops[tap_next(4'(s), 1'b0)];
                    d1 = hops[tap_next(4'(s), 1'b1)];
                    if (d0 != 255 && d0 + 1 < hops[s]) begin
                        hops[s] = d0 + 1;
                    end
                    if (d1 != 255 && d1 + 1 < hops[s]) begin
                        hops[s] = d1 + 1;
                    end
                end
            end
            for (s = 0; s < 16; s++) begin
                if (s != tg) begin
                    tab[tg * 16 + s] = (hops[tap_next(4'(s), 1'b0)] == hops[s] - 1) ? 1'b0
                                                                                     : 1'b1;
                end
            end
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

>>> sv/jtm_shifter.sv
`timescale 1ns / 1ps
`default_nettype none

module jtm_shifter
    import jtm_pkg::*;
#(
    parameter int MAX_SHIFT_BITS = 64
) (
    input  wire logic                      aclk,
    input  wire shift_ctl_t                ctl,
    input  wire logic [MAX_SHIFT_BITS-1:0] load_data,
    output logic                           bit_out
);

    logic [MAX_SHIFT_BITS-1:0] data_reg;
    logic [MAX_SHIFT_BITS-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctl.load) begin
            data_next = load_data;
        end else if (ctl.shift) begin
            data_next = {1'b0, data_reg[MAX_SHIFT_BITS-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign bit_out = data_reg[0];

endmodule

`default_nettype wire

>>> sv/jtm_tap_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

module jtm_tap_tracker
    import jtm_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire tap_step_t  step,
    input  wire tap_state_t target,
    output tap_state_t      state,
    output tap_state_t      state_after,
    output logic            hop_tms
);

    localparam logic [255:0] HOP_TABLE = build_hop_table();

    tap_state_t state_reg;
    tap_state_t state_next;

    assign state_after = tap_next(state_reg, step.tms);
    assign hop_tms     = HOP_TABLE[{target, state_reg}];

    always_comb begin
        state_next = state_reg;
        if (step.advance) begin
            state_next = state_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= TAP_RESET;
        end else begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

`default_nettype wire

>>> sv/jtag_tap_master_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// JTAG TAP master sequencer. One command transfer on the s_ side turns into
// one result transfer per TCK pulse on the m_ side, each giving TMS, TDI,
// the TAP state after the pulse, and a last flag on the final pulse. A reset
// command gives max(reset count, 5) pulses, a move gives the length of the
// shortest TMS path (none if already there), and a shift gives shift_length
// pulses, capped at MAX_SHIFT_BITS, with the data sent LSB first through a
// shift register that moves one bit per pulse.
// The sequencer issues one pulse per cycle while the result register is
// free; a new command is taken only after the last pulse of the previous
// one is in the result register. The reset count register is written
// through cfg_we/cfg_wdata; the user must write it only while the block is
// idle, which the block itself does not enforce.

module jtag_tap_master_sequencer
    import jtm_pkg::*;
#(
    parameter int MAX_SHIFT_BITS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_kind,
    input  wire logic [3:0]  s_target_state,
    input  wire logic [63:0] s_shift_data,
    input  wire logic [6:0]  s_shift_length,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_tms,
    output logic             m_tdi,
    output logic [3:0]       m_tap_state,
    output logic             m_last
);

    localparam int CNT_W = $clog2(MAX_SHIFT_BITS + 1);

    seq_state_t state_reg;
    seq_state_t state_next;

    logic [3:0]       reset_count_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    tap_state_t       target_reg;

    logic m_valid_reg;
    logic m_tms_reg;
    logic m_tdi_reg;
    logic [3:0] m_tap_state_reg;
    logic m_last_reg;

    tap_step_t  step;
    shift_ctl_t shift_ctl;
    tap_state_t tap_state;
    tap_state_t tap_after;
    logic       hop_tms;
    logic       shift_bit;

    logic       out_free;
    logic       accept;
    logic       pulse;
    logic       pulse_tms;
    logic       pulse_tdi;
    logic       pulse_last;
    logic [3:0] reset_pulses;
    logic [CNT_W-1:0] shift_pulses;

    jtm_tap_tracker u_tracker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .target      (target_reg),
        .state       (tap_state),
        .state_after (tap_after),
        .hop_tms     (hop_tms)
    );

    jtm_shifter #(
        .MAX_SHIFT_BITS (MAX_SHIFT_BITS)
    ) u_shifter (
        .aclk      (aclk),
        .ctl       (shift_ctl),
        .load_data (s_shift_data[MAX_SHIFT_BITS-1:0]),
        .bit_out   (shift_bit)
    );

    assign out_free     = !m_valid_reg || m_ready;
    assign accept       = s_valid && s_ready;
    assign reset_pulses = (reset_count_reg < MIN_RESET_CLOCKS) ? MIN_RESET_CLOCKS
                                                               : reset_count_reg;
    assign shift_pulses = (s_shift_length > 7'(MAX_SHIFT_BITS)) ? CNT_W'(MAX_SHIFT_BITS)
                                                                : CNT_W'(s_shift_length);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE: begin
                if (s_valid) begin
                    unique case (cmd_kind_t'(s_kind))
                        KIND_RESET: state_next = SEQ_RESET;
                        KIND_MOVE:  state_next = (tap_state != s_target_state) ? SEQ_MOVE
                                                                               : SEQ_IDLE;
                        KIND_SHIFT: state_next = (s_shift_length != 7'd0) ? SEQ_SHIFT
                                                                          : SEQ_IDLE;
                        default:    state_next = SEQ_IDLE;
                    endcase
                end
            end
            SEQ_RESET, SEQ_MOVE, SEQ_SHIFT: begin
                if (pulse && pulse_last) begin
                    state_next = SEQ_IDLE;
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        pulse      = 1'b0;
        pulse_tms  = 1'b0;
        pulse_tdi  = 1'b0;
        pulse_last = 1'b0;
        unique case (state_reg)
            SEQ_IDLE: begin
                s_ready = 1'b1;
            end
            SEQ_RESET: begin
                pulse      = out_free;
                pulse_tms  = 1'b1;
                pulse_last = (cnt_reg == CNT_W'(1));
            end
            SEQ_MOVE: begin
                pulse      = out_free;
                pulse_tms  = hop_tms;
                pulse_last = (tap_after == target_reg);
            end
            SEQ_SHIFT: begin
                pulse      = out_free;
                pulse_tms  = (cnt_reg == CNT_W'(1));
                pulse_tdi  = shift_bit;
                pulse_last = (cnt_reg == CNT_W'(1));
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign step.advance    = pulse;
    assign step.tms        = pulse_tms;
    assign shift_ctl.load  = accept;
    assign shift_ctl.shift = pulse;

    always_comb begin
        cnt_next = cnt_reg;
        if (accept) begin
            cnt_next = (cmd_kind_t'(s_kind) == KIND_RESET) ? CNT_W'(reset_pulses)
                                                           : shift_pulses;
        end else if (pulse) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= SEQ_IDLE;
            reset_count_reg <= RESET_CLOCKS_DEFAULT;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                reset_count_reg <= cfg_wdata;
            end
            if (pulse) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        if (accept) begin
            target_reg <= s_target_state;
        end
        if (pulse) begin
            m_tms_reg       <= pulse_tms;
            m_tdi_reg       <= pulse_tdi;
            m_tap_state_reg <= tap_after;
            m_last_reg      <= pulse_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_tms       = m_tms_reg;
    assign m_tdi       = m_tdi_reg;
    assign m_tap_state = m_tap_state_reg;
    assign m_last      = m_last_reg;

endmodule

`default_nettype wire

>>> sv/jtm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module jtm_checker
    import jtm_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_tms,
    input wire logic       m_tdi,
    input wire logic [3:0] m_tap_state,
    input wire logic       m_last
);

    // A stalled result transfer holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable({m_tms, m_tdi, m_tap_state, m_last}))
        else $error("result changed while stalled");

    // Data on TDI only comes from a shift, where TMS is high exactly on the last bit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tdi |-> m_tms == m_last)
        else $error("TDI set outside a shift");

    // Test-logic-reset is only entered or kept with TMS high.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tap_state == TAP_RESET |-> m_tms)
        else $error("reached test-logic-reset with TMS low");

    // Shift-DR is only entered or kept with TMS low.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tap_state == TAP_SHIFT_DR |-> !m_tms)
        else $error("reached shift-DR with TMS high");

endmodule

bind jtag_tap_master_sequencer jtm_checker u_jtm_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_tms       (m_tms),
    .m_tdi       (m_tdi),
    .m_tap_state (m_tap_state),
    .m_last      (m_last)
);

`default_nettype wire
